// ===== hw/rtl/pce_pkg.sv =====
package pce_pkg;

   localparam int MAX_ENTRY_LEN_DEFAULT = 256;
   localparam int RESTART_GAP_RESET     = 16;

   localparam int POS_W          = 16;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int PREFIX_LEN_W   = 9;
   localparam int CSR_W          = 8;

   // request kind and result kind codes
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_EMPTY = 1'b1;
   localparam logic RES_SUFFIX = 1'b0;
   localparam logic RES_HEADER = 1'b1;

   // queue between front and back
   localparam int MID_DEPTH = 4;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   // result queue, a power of two, taking up to two writes a cycle
   localparam int OUT_DEPTH = 4;

   typedef struct packed {
      logic       kind;
      logic [7:0] entry_byte;
      logic       end_of_entry;
   } req_type;

   typedef struct packed {
      logic                    result_kind;
      logic [7:0]              suffix_byte;
      logic [PREFIX_LEN_W-1:0] prefix_len;
      logic [15:0]             suffix_len;
      logic                    restart;
      logic [31:0]             entry_offset;
      logic [31:0]             entry_number;
      logic                    truncated;
      logic                    last;
   } rsp_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic             is_byte;
      logic [7:0]       entry_byte;
      logic             ends;
      logic             in_prev;
      logic             restart;
      logic             truncated;
      logic [POS_W-1:0] pos_after;
      logic [7:0]       prev_byte;
   } mid_type;

endpackage

// ===== hw/rtl/pce_ram.sv =====
module pce_ram import pce_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = MAX_ENTRY_LEN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pce_queue.sv =====
module pce_queue import pce_pkg::*; #(
   parameter type item_type = mid_type,
   parameter int  DEPTH     = MID_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  item_type                     push_data,
   input  logic                         pop,
   output logic                         valid,
   output item_type                     head,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ===== hw/rtl/pce_front.sv =====
module pce_front import pce_pkg::*; #(
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [MID_CNT_W-1:0] q_count,
   output logic                 q_push,
   output mid_type              q_data
);

   localparam int ADDR_W = $clog2(MAX_ENTRY_LEN);
   localparam int LEN_W  = $clog2(MAX_ENTRY_LEN + 1);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ENTRY_LEN);

   logic [CSR_W-1:0] interval_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] prev_len_ff, prev_len_in;
   logic [7:0]       phase_ff, phase_in;
   logic             s1_valid_ff;
   mid_type          s1_ff, s1_in;

   logic             accept;
   logic             is_byte;
   logic             ends;
   logic [POS_W-1:0] pos_after;
   logic             truncated;
   logic [8:0]       phase_next;
   logic             ram_we;
   logic [7:0]       ram_rdata;

   // count the request still waiting on the store read
   assign req_full = ({1'b0, q_count} + (MID_CNT_W + 1)'(s1_valid_ff))
                     >= (MID_CNT_W + 1)'(MID_DEPTH);
   assign accept   = req_push && !req_full;

   assign is_byte    = (req_data.kind == KIND_BYTE);
   assign ends       = (req_data.kind == KIND_EMPTY) || req_data.end_of_entry;
   assign pos_after  = (is_byte && pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign truncated  = pos_after > MAX_POS;
   assign phase_next = {1'b0, phase_ff} + 9'd1;
   assign ram_we     = accept && is_byte && (pos_ff < MAX_POS);

   always_comb begin
      pos_in      = pos_ff;
      prev_len_in = prev_len_ff;
      phase_in    = phase_ff;
      if (accept) begin
         if (ends) begin
            pos_in      = '0;
            prev_len_in = truncated ? LEN_W'(MAX_ENTRY_LEN) : pos_after[LEN_W-1:0];
            phase_in    = (phase_next >= {1'b0, interval_ff}) ? '0 : phase_next[7:0];
         end else begin
            pos_in = pos_after;
         end
      end
   end

   always_comb begin
      s1_in            = '0;
      s1_in.is_byte    = is_byte;
      s1_in.entry_byte = req_data.entry_byte;
      s1_in.ends       = ends;
      s1_in.in_prev    = (pos_ff < POS_W'(prev_len_ff)) && (pos_ff < MAX_POS);
      s1_in.restart    = (phase_ff == '0);
      s1_in.truncated  = truncated;
      s1_in.pos_after  = pos_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= CSR_W'(RESTART_GAP_RESET);
         pos_ff      <= '0;
         prev_len_ff <= '0;
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
         pos_ff      <= pos_in;
         prev_len_ff <= prev_len_in;
         phase_ff    <= phase_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   pce_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ENTRY_LEN)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (pos_ff[ADDR_W-1:0]),
      .wdata (req_data.entry_byte),
      .raddr (pos_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // merge the store byte as the request enters the queue
   always_comb begin
      q_data           = s1_ff;
      q_data.prev_byte = ram_rdata;
   end

   assign q_push = s1_valid_ff;

endmodule

// ===== hw/rtl/pce_back.sv =====
module pce_back import pce_pkg::*; #(
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  mid_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int LEN_W     = $clog2(MAX_ENTRY_LEN + 1);
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   function automatic logic [2:0] varint_size(input logic [31:0] v);
      logic [2:0] n;
      if (v < 32'd128) begin
         n = 3'd1;
      end else if (v < 32'd16384) begin
         n = 3'd2;
      end else if (v < 32'd2097152) begin
         n = 3'd3;
      end else if (v < 32'd268435456) begin
         n = 3'd4;
      end else begin
         n = 3'd5;
      end
      return n;
   endfunction

   logic             still_ff, still_in;
   logic [LEN_W-1:0] shared_ff, shared_in;
   logic [31:0]      entry_cnt_ff, entry_cnt_in;
   logic [31:0]      page_ff, page_in;

   rsp_type              out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic        go;
   logic        shared;
   logic        byte_out;
   logic        hdr_out;
   logic [15:0] suffix;
   logic        pop_ok;
   rsp_type     byte_rsp;
   rsp_type     hdr_rsp;
   rsp_type     res0;

   // hold while the result queue cannot take two results
   assign go     = q_valid && (out_cnt_ff <= OUT_CNT_W'(OUT_DEPTH - 2));
   assign q_pop  = go;
   assign pop_ok = rsp_pop && !rsp_empty;

   assign shared = q_data.is_byte && !q_data.restart && still_ff && q_data.in_prev
                   && (q_data.prev_byte == q_data.entry_byte);
   assign byte_out  = q_data.is_byte && !shared;
   assign hdr_out   = q_data.ends;
   assign shared_in = shared ? shared_ff + 1'b1 : shared_ff;
   assign suffix    = (q_data.pos_after == POS_MAX) ? POS_MAX
                      : q_data.pos_after - POS_W'(shared_in);

   always_comb begin
      byte_rsp             = '0;
      byte_rsp.result_kind = RES_SUFFIX;
      byte_rsp.suffix_byte = q_data.entry_byte;
      byte_rsp.last        = !q_data.ends;

      hdr_rsp              = '0;
      hdr_rsp.result_kind  = RES_HEADER;
      hdr_rsp.prefix_len   = PREFIX_LEN_W'(shared_in);
      hdr_rsp.suffix_len   = suffix;
      hdr_rsp.restart      = q_data.restart;
      hdr_rsp.entry_offset = page_ff;
      hdr_rsp.entry_number = entry_cnt_ff;
      hdr_rsp.truncated    = q_data.truncated;
      hdr_rsp.last         = 1'b1;

      res0 = byte_out ? byte_rsp : hdr_rsp;
   end

   always_comb begin
      still_in     = still_ff;
      entry_cnt_in = entry_cnt_ff;
      page_in      = page_ff;
      if (go) begin
         if (hdr_out) begin
            still_in     = 1'b1;
            entry_cnt_in = entry_cnt_ff + 32'd1;
            page_in      = page_ff + 32'(varint_size(32'(shared_in)))
                           + 32'(varint_size(32'(suffix))) + 32'(suffix);
         end else if (byte_out) begin
            still_in = 1'b0;
         end
      end
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      out_cnt_in = out_cnt_ff;
      if (go) begin
         wr_ptr_in  = wr_ptr_ff + OUT_PTR_W'(byte_out) + OUT_PTR_W'(hdr_out);
         out_cnt_in = out_cnt_in + OUT_CNT_W'(byte_out) + OUT_CNT_W'(hdr_out);
      end
      if (pop_ok) begin
         rd_ptr_in  = rd_ptr_ff + 1'b1;
         out_cnt_in = out_cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         still_ff     <= 1'b1;
         shared_ff    <= '0;
         entry_cnt_ff <= '0;
         page_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_cnt_ff   <= '0;
      end else begin
         still_ff     <= still_in;
         entry_cnt_ff <= entry_cnt_in;
         page_ff      <= page_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_cnt_ff   <= out_cnt_in;
         if (go) begin
            shared_ff <= hdr_out ? '0 : shared_in;
         end
      end
   end

   // the header always lands after the suffix byte of the same request
   always_ff @(posedge clock) begin
      if (go && (byte_out || hdr_out)) begin
         out_mem_ff[wr_ptr_ff] <= res0;
      end
      if (go && byte_out && hdr_out) begin
         out_mem_ff[wr_ptr_ff + 1'b1] <= hdr_rsp;
      end
   end

   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp_data  = out_mem_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/prefix_compression_encoder_core.sv =====
// Prefix compression encoder with restart points.
// Requests: push one entry byte per request, kind low; end_of_entry closes the
// entry, and kind high closes it with no byte. Accepted on push with full low.
// Results: while empty is low the oldest result is on rsp_data; pop takes it.
// Every byte from the first that breaks the run of bytes equal to the previous
// entry on comes out as a suffix byte, as does every byte of a restart entry;
// the end of an entry gives one header record. csr_we writes restart_interval
// (reset 16); the user must use it only while idle, the block does not enforce
// it. A request is registered with its byte store read, queued, then compared
// and counted as its results enter the result queue. Throughput: one request
// per cycle while full stays low; results leave at one per cycle, so a request
// giving a suffix byte and a header takes two pops.
// Reset clears all counters and both queues and sets restart_interval to 16;
// the byte store is not cleared, as only positions written in the previous
// entry are read.
// When pop stays low the four-deep result queue fills, the back end holds, the
// four-deep request queue fills and full rises; nothing is lost.
module prefix_compression_encoder_core import pce_pkg::*; #(
   parameter int MAX_ENTRY_LEN = MAX_ENTRY_LEN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic                 q_push;
   mid_type              q_push_data;
   logic                 q_pop;
   logic                 q_valid;
   mid_type              q_head;
   logic [MID_CNT_W-1:0] q_count;

   pce_front #(
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   pce_queue #(
      .item_type (mid_type),
      .DEPTH     (MID_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   pce_back #(
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= MID_CNT_W'(MID_DEPTH))
      else $error("request queue overfilled");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end took from an empty request queue");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == RES_HEADER) |-> rsp_data.last)
      else $error("header not marked last");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind == RES_SUFFIX) |->
         (rsp_data.suffix_len == '0 && rsp_data.entry_number == '0
          && rsp_data.entry_offset == '0 && !rsp_data.restart))
      else $error("suffix byte carries header fields");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb import pce_pkg::*; ();

   localparam int MAX_LEN       = MAX_ENTRY_LEN_DEFAULT;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   req_type          req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   prefix_compression_encoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   req_type     req_backlog[$];
   rsp_type     expected_records[$];
   logic [7:0]  last_entry_bytes[$];
   int          tx_idle_pct = 31;
   int          rx_idle_pct = 77;
   int          error_count = 0;
   int          stall_cycles = 0;

   // encoder state as the testbench sees it
   logic [7:0]  prev_bytes [MAX_LEN];
   int unsigned prev_len = 0;
   int unsigned byte_pos = 0;
   int unsigned shared_cnt = 0;
   int unsigned entry_no = 0;
   int unsigned phase = 0;
   bit          matching = 1'b1;
   logic [31:0] page_off = '0;
   logic [7:0]  restart_interval = 8'd16;

   function automatic int unsigned varint_len(input int unsigned v);
      int unsigned n;
      n = 1;
      while (v >= 128) begin
         v = v >> 7;
         n++;
      end
      return n;
   endfunction

   task automatic encode_request(input req_type r);
      rsp_type     rec;
      bit          is_restart;
      bit          trunc;
      int unsigned suffix;
      is_restart = (phase == 0);
      if (r.kind == KIND_BYTE) begin
         if (!is_restart && matching && byte_pos < prev_len && byte_pos < MAX_LEN &&
             prev_bytes[byte_pos] == r.entry_byte) begin
            shared_cnt++;
         end else begin
            matching = 1'b0;
            rec = '0;
            rec.result_kind = RES_SUFFIX;
            rec.suffix_byte = r.entry_byte;
            rec.last = !r.end_of_entry;
            expected_records.insert(expected_records.size(), rec);
         end
         if (byte_pos < MAX_LEN)
            prev_bytes[byte_pos] = r.entry_byte;
         if (byte_pos < POS_MAX)
            byte_pos++;
      end
      if (r.kind == KIND_EMPTY || r.end_of_entry) begin
         suffix = (byte_pos >= POS_MAX) ? POS_MAX : byte_pos - shared_cnt;
         trunc = byte_pos > MAX_LEN;
         rec = '0;
         rec.result_kind = RES_HEADER;
         rec.prefix_len = PREFIX_LEN_W'(shared_cnt);
         rec.suffix_len = 16'(suffix);
         rec.restart = is_restart;
         rec.entry_offset = page_off;
         rec.entry_number = entry_no;
         rec.truncated = trunc;
         rec.last = 1'b1;
         expected_records.insert(expected_records.size(), rec);
         page_off = page_off + varint_len(shared_cnt) + varint_len(suffix) + suffix;
         prev_len = trunc ? MAX_LEN : byte_pos;
         entry_no++;
         phase++;
         if (phase >= restart_interval)
            phase = 0;
         byte_pos = 0;
         shared_cnt = 0;
         matching = 1'b1;
      end
   endtask

   // request driver: hold the request while full, else offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            encode_request(req_data);
         if (!req_push || !req_full) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_push <= 1'b1;
               req_data <= req_backlog.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_records.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: unexpected result %p", $realtime, rsp_data);
               error_count++;
            end else begin
               want = expected_records.pop_front();
               if (rsp_data.result_kind !== want.result_kind ||
                   rsp_data.suffix_byte !== want.suffix_byte ||
                   rsp_data.prefix_len !== want.prefix_len ||
                   rsp_data.suffix_len !== want.suffix_len ||
                   rsp_data.restart !== want.restart ||
                   rsp_data.entry_offset !== want.entry_offset ||
                   rsp_data.entry_number !== want.entry_number ||
                   rsp_data.truncated !== want.truncated ||
                   rsp_data.last !== want.last) begin
                  if (error_count < REPORT_LIMIT)
                     $display("%0t: mismatch, expected %p, got %p", $realtime, want, rsp_data);
                  error_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic void queue_request(input logic kind, input logic [7:0] b,
                                         input logic ends);
      req_type r;
      r.kind = kind;
      r.entry_byte = b;
      r.end_of_entry = ends;
      req_backlog.insert(req_backlog.size(), r);
   endfunction

   // copy up to share bytes from the last entry, fill the rest at random
   function automatic int add_entry(input int len, input int share, input bit empty_close);
      logic [7:0] bytes[$];
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         if (i < share && i < last_entry_bytes.size())
            b = last_entry_bytes[i];
         else
            b = 8'($urandom_range(255));
         bytes.insert(bytes.size(), b);
         queue_request(KIND_BYTE, b, !empty_close && i == len - 1);
      end
      if (empty_close || len == 0)
         queue_request(KIND_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      last_entry_bytes = bytes;
      return len + ((empty_close || len == 0) ? 1 : 0);
   endfunction

   function automatic int random_group();
      int mode;
      int len;
      mode = $urandom_range(99);
      if (mode < 8) begin
         queue_request(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
         return 1;
      end
      if (mode < 10)
         len = $urandom_range(250, 300);
      else if (mode < 30)
         len = last_entry_bytes.size();
      else if (mode < 45)
         len = last_entry_bytes.size() + $urandom_range(1, 3);
      else
         len = $urandom_range(0, 10);
      return add_entry(len, (mode < 45) ? last_entry_bytes.size() : $urandom_range(0, len),
                       $urandom_range(3) == 0);
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_push || expected_records.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_interval(input logic [7:0] value);
      wait_drained();
      restart_interval = value;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_segment(input logic [7:0] intv, input int tx_pct, input int rx_pct,
                              input int n_items);
      int added;
      bit held;
      set_interval(intv);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      added = 0;
      held = 1'b0;
      while (added < n_items) begin
         // let every outstanding result drain before carrying on
         if (!held && added >= n_items / 2) begin
            wait_drained();
            held = 1'b1;
         end
         added += random_group();
      end
   endtask

   initial begin
      // entries under the reset interval
      queue_request(KIND_BYTE, 8'h00, 1'b0);
      queue_request(KIND_BYTE, 8'hFF, 1'b1);
      queue_request(KIND_BYTE, 8'h00, 1'b0);
      queue_request(KIND_BYTE, 8'hFF, 1'b0);
      queue_request(KIND_BYTE, 8'h80, 1'b1);
      queue_request(KIND_BYTE, 8'h00, 1'b0);
      queue_request(KIND_BYTE, 8'hFF, 1'b0);
      queue_request(KIND_BYTE, 8'h80, 1'b0);
      queue_request(KIND_EMPTY, 8'hFF, 1'b0);
      queue_request(KIND_EMPTY, 8'h55, 1'b1);
      queue_request(KIND_BYTE, 8'h7F, 1'b1);
      queue_request(KIND_BYTE, 8'h7F, 1'b0);
      queue_request(KIND_BYTE, 8'h01, 1'b1);
      queue_request(KIND_BYTE, 8'h7F, 1'b0);
      queue_request(KIND_BYTE, 8'h01, 1'b0);
      queue_request(KIND_BYTE, 8'hAA, 1'b1);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // zero interval: every entry restarts, nothing is shared
      set_interval(8'd0);
      queue_request(KIND_BYTE, 8'h33, 1'b1);
      queue_request(KIND_BYTE, 8'h33, 1'b1);
      queue_request(KIND_EMPTY, 8'h00, 1'b1);

      // over-long entries: sharing stops at the store size
      set_interval(8'd255);
      void'(add_entry(260, 0, 1'b0));
      void'(add_entry(260, 260, 1'b0));

      run_segment(8'd255, 31, 77, 110);
      run_segment(8'd1,   31, 77, 110);
      run_segment(8'd7,   77, 31, 110);
      run_segment(8'd0,   77, 31, 110);
      run_segment(8'd3,    0,  0, 110);
      run_segment(8'd16,   0,  0, 110);

      wait_drained();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pce_pkg.sv
hw/rtl/pce_ram.sv
hw/rtl/pce_queue.sv
hw/rtl/pce_front.sv
hw/rtl/pce_back.sv
hw/rtl/prefix_compression_encoder_core.sv
dv/tb.sv
